### sv/agcid_pkg.sv
// Package with the mnemonic codes, special instruction words and result types of the decoder.
`timescale 1ns / 1ps
`default_nettype none

package agcid_pkg;

   localparam int AddrWidth     = 16;
   localparam int WordWidth     = 15;
   localparam int MnemonicWidth = 6;
   localparam int OperandWidth  = 12;
   localparam int FormWidth     = 2;

   typedef logic [AddrWidth-1:0]     addr_type;
   typedef logic [WordWidth-1:0]     word_type;
   typedef logic [MnemonicWidth-1:0] mnemonic_type;
   typedef logic [OperandWidth-1:0]  operand_type;
   typedef logic [FormWidth-1:0]     form_type;

   localparam mnemonic_type MN_COM    = 6'd0;
   localparam mnemonic_type MN_DDOUBL = 6'd1;
   localparam mnemonic_type MN_DOUBLE = 6'd2;
   localparam mnemonic_type MN_DTCB   = 6'd3;
   localparam mnemonic_type MN_DTCF   = 6'd4;
   localparam mnemonic_type MN_EXTEND = 6'd5;
   localparam mnemonic_type MN_INHINT = 6'd6;
   localparam mnemonic_type MN_NOOP   = 6'd7;
   localparam mnemonic_type MN_OVSK   = 6'd8;
   localparam mnemonic_type MN_RELINT = 6'd9;
   localparam mnemonic_type MN_RESUME = 6'd10;
   localparam mnemonic_type MN_RETURN = 6'd11;
   localparam mnemonic_type MN_TCAA   = 6'd12;
   localparam mnemonic_type MN_XLQ    = 6'd13;
   localparam mnemonic_type MN_XXALQ  = 6'd14;
   localparam mnemonic_type MN_ZL     = 6'd15;
   localparam mnemonic_type MN_TC     = 6'd16;
   localparam mnemonic_type MN_CCS    = 6'd17;
   localparam mnemonic_type MN_TCF    = 6'd18;
   localparam mnemonic_type MN_DAS    = 6'd19;
   localparam mnemonic_type MN_LXCH   = 6'd20;
   localparam mnemonic_type MN_INCR   = 6'd21;
   localparam mnemonic_type MN_ADS    = 6'd22;
   localparam mnemonic_type MN_CA     = 6'd23;
   localparam mnemonic_type MN_CS     = 6'd24;
   localparam mnemonic_type MN_INDEX  = 6'd25;
   localparam mnemonic_type MN_DXCH   = 6'd26;
   localparam mnemonic_type MN_TS     = 6'd27;
   localparam mnemonic_type MN_XCH    = 6'd28;
   localparam mnemonic_type MN_AD     = 6'd29;
   localparam mnemonic_type MN_MASK   = 6'd30;
   localparam mnemonic_type MN_DCOM   = 6'd31;
   localparam mnemonic_type MN_SQUARE = 6'd32;
   localparam mnemonic_type MN_ZQ     = 6'd33;
   localparam mnemonic_type MN_READ   = 6'd34;
   localparam mnemonic_type MN_DV     = 6'd42;
   localparam mnemonic_type MN_BZF    = 6'd43;
   localparam mnemonic_type MN_MSU    = 6'd44;
   localparam mnemonic_type MN_QXCH   = 6'd45;
   localparam mnemonic_type MN_AUG    = 6'd46;
   localparam mnemonic_type MN_DIM    = 6'd47;
   localparam mnemonic_type MN_DCA    = 6'd48;
   localparam mnemonic_type MN_DCS    = 6'd49;
   localparam mnemonic_type MN_SU     = 6'd50;
   localparam mnemonic_type MN_BZMF   = 6'd51;
   localparam mnemonic_type MN_MP     = 6'd52;

   localparam form_type FORM_NONE    = 2'd0;
   localparam form_type FORM_CHANNEL = 2'd1;
   localparam form_type FORM_ADDRESS = 2'd2;

   localparam word_type W_COM    = 15'o40000;
   localparam word_type W_DDOUBL = 15'o20001;
   localparam word_type W_DOUBLE = 15'o60000;
   localparam word_type W_DTCB   = 15'o52006;
   localparam word_type W_DTCF   = 15'o52005;
   localparam word_type W_EXTEND = 15'o6;
   localparam word_type W_INHINT = 15'o4;
   localparam word_type W_NOOP_E = 15'o30000;
   localparam word_type W_OVSK   = 15'o54000;
   localparam word_type W_RELINT = 15'o3;
   localparam word_type W_RESUME = 15'o50017;
   localparam word_type W_RETURN = 15'o2;
   localparam word_type W_TCAA   = 15'o54005;
   localparam word_type W_XLQ    = 15'o1;
   localparam word_type W_XXALQ  = 15'o0;
   localparam word_type W_ZL     = 15'o22007;
   localparam word_type W_DCOM   = 15'o40001;
   localparam word_type W_SQUARE = 15'o70000;
   localparam word_type W_NOOP_X = 15'd10000;

   localparam addr_type ERASABLE_TOP = 16'o2000;

   typedef struct packed {
      mnemonic_type mnemonic;
      operand_type  operand;
      form_type     operand_form;
      logic         was_extracode;
   } result_type;

endpackage

`default_nettype wire

### sv/agcid_decode.sv
// Combinational decode of one instruction word and the next extend flag.
`timescale 1ns / 1ps
`default_nettype none

module agcid_decode (
   input  agcid_pkg::addr_type   address,
   input  agcid_pkg::word_type   word,
   input  logic                  extend,
   output agcid_pkg::result_type result,
   output logic                  extend_next
);
   import agcid_pkg::*;

   logic        erasable;
   logic [2:0]  top;
   logic [1:0]  hi;
   logic [16:0] addr_plus;
   logic [9:0]  dec10;
   logic [11:0] dec12;
   logic [11:0] op10;
   logic [11:0] op12;

   assign erasable  = address < ERASABLE_TOP;
   assign top       = word[14:12];
   assign hi        = word[11:10];
   assign addr_plus = {1'b0, address} + 17'd1;
   assign dec10     = word[9:0] - 10'd1;
   assign dec12     = word[11:0] - 12'd1;
   assign op10      = {2'b00, word[9:0]};
   assign op12      = word[11:0];

   always_comb begin
      result.mnemonic      = MN_COM;
      result.operand       = '0;
      result.operand_form  = FORM_NONE;
      result.was_extracode = extend;
      extend_next          = 1'b0;
      if (!extend) begin
         if (word == W_COM) begin
            result.mnemonic = MN_COM;
         end else if (word == W_DDOUBL) begin
            result.mnemonic = MN_DDOUBL;
         end else if (word == W_DOUBLE) begin
            result.mnemonic = MN_DOUBLE;
         end else if (word == W_DTCB) begin
            result.mnemonic = MN_DTCB;
         end else if (word == W_DTCF) begin
            result.mnemonic = MN_DTCF;
         end else if (word == W_EXTEND) begin
            result.mnemonic = MN_EXTEND;
            extend_next     = 1'b1;
         end else if (word == W_INHINT) begin
            result.mnemonic = MN_INHINT;
         end else if (!erasable && ({2'b00, word} == addr_plus) && (word != W_NOOP_X)) begin
            result.mnemonic = MN_NOOP;
         end else if (erasable && (word == W_NOOP_E)) begin
            result.mnemonic = MN_NOOP;
         end else if (word == W_OVSK) begin
            result.mnemonic = MN_OVSK;
         end else if (word == W_RELINT) begin
            result.mnemonic = MN_RELINT;
         end else if (word == W_RESUME) begin
            result.mnemonic = MN_RESUME;
         end else if (word == W_RETURN) begin
            result.mnemonic = MN_RETURN;
         end else if (word == W_TCAA) begin
            result.mnemonic = MN_TCAA;
         end else if (word == W_XLQ) begin
            result.mnemonic = MN_XLQ;
         end else if (word == W_XXALQ) begin
            result.mnemonic = MN_XXALQ;
         end else if (word == W_ZL) begin
            result.mnemonic = MN_ZL;
         end else begin
            result.operand_form = FORM_ADDRESS;
            case (top)
               3'd0: begin
                  result.mnemonic = MN_TC;
                  result.operand  = op12;
               end
               3'd1: begin
                  if (hi == 2'd0) begin
                     result.mnemonic = MN_CCS;
                     result.operand  = op10;
                  end else begin
                     result.mnemonic = MN_TCF;
                     result.operand  = op12;
                  end
               end
               3'd2: begin
                  result.operand = op10;
                  case (hi)
                     2'd0: begin
                        result.mnemonic = MN_DAS;
                        result.operand  = {2'b00, dec10};
                     end
                     2'd1: result.mnemonic = MN_LXCH;
                     2'd2: result.mnemonic = MN_INCR;
                     default: result.mnemonic = MN_ADS;
                  endcase
               end
               3'd3: begin
                  result.mnemonic = MN_CA;
                  result.operand  = op12;
               end
               3'd4: begin
                  result.mnemonic = MN_CS;
                  result.operand  = op12;
               end
               3'd5: begin
                  result.operand = op10;
                  case (hi)
                     2'd0: result.mnemonic = MN_INDEX;
                     2'd1: begin
                        result.mnemonic = MN_DXCH;
                        result.operand  = {2'b00, dec10};
                     end
                     2'd2: result.mnemonic = MN_TS;
                     default: result.mnemonic = MN_XCH;
                  endcase
               end
               3'd6: begin
                  result.mnemonic = MN_AD;
                  result.operand  = op12;
               end
               default: begin
                  result.mnemonic = MN_MASK;
                  result.operand  = op12;
               end
            endcase
         end
      end else begin
         if (word == W_DCOM) begin
            result.mnemonic = MN_DCOM;
         end else if (word == W_RESUME) begin
            result.mnemonic = MN_RESUME;
         end else if (word == W_SQUARE) begin
            result.mnemonic = MN_SQUARE;
         end else if (word == W_ZL) begin
            result.mnemonic = MN_ZQ;
         end else begin
            result.operand_form = FORM_ADDRESS;
            case (top)
               3'd0: begin
                  result.mnemonic     = MN_READ + {3'b000, word[11:9]};
                  result.operand      = {3'b000, word[8:0]};
                  result.operand_form = FORM_CHANNEL;
               end
               3'd1: begin
                  if (hi == 2'd0) begin
                     result.mnemonic = MN_DV;
                     result.operand  = op10;
                  end else begin
                     result.mnemonic = MN_BZF;
                     result.operand  = op12;
                  end
               end
               3'd2: begin
                  result.operand = op10;
                  case (hi)
                     2'd0: result.mnemonic = MN_MSU;
                     2'd1: result.mnemonic = MN_QXCH;
                     2'd2: result.mnemonic = MN_AUG;
                     default: result.mnemonic = MN_DIM;
                  endcase
               end
               3'd3: begin
                  result.mnemonic = MN_DCA;
                  result.operand  = dec12;
               end
               3'd4: begin
                  result.mnemonic = MN_DCS;
                  result.operand  = dec12;
               end
               3'd5: begin
                  result.mnemonic = MN_INDEX;
                  result.operand  = op12;
                  extend_next     = 1'b1;
               end
               3'd6: begin
                  if (hi == 2'd0) begin
                     result.mnemonic = MN_SU;
                     result.operand  = op10;
                  end else begin
                     result.mnemonic = MN_BZMF;
                     result.operand  = op12;
                  end
               end
               default: begin
                  result.mnemonic = MN_MP;
                  result.operand  = op12;
               end
            endcase
         end
      end
   end

endmodule

`default_nettype wire

### sv/agc_instruction_decoder.sv
// Top level of the instruction decoder: input register, decode and result register.
//
//   channel  direction  ports                                      transfer
//   req      in         req_valid, req_stall, req_address, req_word  valid & !stall
//   rsp      out        rsp_valid, rsp_stall, rsp_mnemonic, rsp_operand,
//                       rsp_operand_form, rsp_was_extracode          valid & !stall
//
// One word per cycle is accepted while req_stall is low; each word is decoded between the input
// register and the result register, and its result is shown from the result register.
// The extend flag updates as a word moves from the input register to the result register.
// Reset empties both registers and clears the extend flag.
// A stalled result holds both stages; req_stall rises only while the input register is full.
`timescale 1ns / 1ps
`default_nettype none

module agc_instruction_decoder (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  agcid_pkg::addr_type     req_address,
   input  agcid_pkg::word_type     req_word,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output agcid_pkg::mnemonic_type rsp_mnemonic,
   output agcid_pkg::operand_type  rsp_operand,
   output agcid_pkg::form_type     rsp_operand_form,
   output logic                    rsp_was_extracode
);
   import agcid_pkg::*;

   logic       in_valid_ff;
   addr_type   in_address_ff;
   word_type   in_word_ff;
   logic       extend_ff;
   logic       extend_in;
   logic       out_valid_ff;
   result_type out_result_ff;
   result_type decoded;
   logic       out_free;
   logic       advance;
   logic       req_take;

   agcid_decode u_decode (
      .address     (in_address_ff),
      .word        (in_word_ff),
      .extend      (extend_ff),
      .result      (decoded),
      .extend_next (extend_in)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         extend_ff    <= 1'b0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            extend_ff <= extend_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_address_ff <= req_address;
         in_word_ff    <= req_word;
      end
      if (advance) begin
         out_result_ff <= decoded;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_mnemonic      = out_result_ff.mnemonic;
   assign rsp_operand       = out_result_ff.operand;
   assign rsp_operand_form  = out_result_ff.operand_form;
   assign rsp_was_extracode = out_result_ff.was_extracode;

endmodule

`default_nettype wire

### sim/agc_instruction_decoder_tb.sv
// Self-checking testbench for the instruction decoder: scoreboard class, directed and random words.
`timescale 1ns / 1ps

module agc_instruction_decoder_tb;
   import agcid_pkg::*;

   // Instruction groups selected by the top three bits of the word.
   localparam logic [2:0] GRP_TC_READ  = 3'd0;
   localparam logic [2:0] GRP_CCS_DV   = 3'd1;
   localparam logic [2:0] GRP_DAS_MSU  = 3'd2;
   localparam logic [2:0] GRP_CA_DCA   = 3'd3;
   localparam logic [2:0] GRP_CS_DCS   = 3'd4;
   localparam logic [2:0] GRP_INDEX    = 3'd5;
   localparam logic [2:0] GRP_AD_SU    = 3'd6;
   localparam logic [2:0] GRP_MASK_MP  = 3'd7;

   localparam mnemonic_type DAS_GROUP [4] = '{MN_DAS, MN_LXCH, MN_INCR, MN_ADS};
   localparam mnemonic_type INDEX_GROUP [4] = '{MN_INDEX, MN_DXCH, MN_TS, MN_XCH};
   localparam mnemonic_type MSU_GROUP [4] = '{MN_MSU, MN_QXCH, MN_AUG, MN_DIM};

   localparam word_type PLAIN_SPECIALS [15] = '{W_COM, W_DDOUBL, W_DOUBLE, W_DTCB, W_DTCF,
      W_EXTEND, W_INHINT, W_OVSK, W_RELINT, W_RESUME, W_RETURN, W_TCAA, W_XLQ, W_XXALQ, W_ZL};
   localparam word_type EXTRA_SPECIALS [5] = '{W_DCOM, W_RESUME, W_SQUARE, W_ZL, W_EXTEND};

   class decode_scoreboard;
      result_type expected_q[$];
      logic       extended;
      int         failures;

      function new();
         extended = 1'b0;
         failures = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function result_type decode(addr_type addr, word_type word);
         result_type r;
         logic [2:0] group;
         logic [1:0] sub;
         word_type   minus_one;
         logic       erasable;
         r = '0;
         r.was_extracode = extended;
         group = word[14:12];
         sub = word[11:10];
         minus_one = word - 15'd1;
         erasable = addr < ERASABLE_TOP;
         if (!extended) begin
            if (word == W_COM) r.mnemonic = MN_COM;
            else if (word == W_DDOUBL) r.mnemonic = MN_DDOUBL;
            else if (word == W_DOUBLE) r.mnemonic = MN_DOUBLE;
            else if (word == W_DTCB) r.mnemonic = MN_DTCB;
            else if (word == W_DTCF) r.mnemonic = MN_DTCF;
            else if (word == W_EXTEND) begin
               r.mnemonic = MN_EXTEND;
               extended = 1'b1;
            end
            else if (word == W_INHINT) r.mnemonic = MN_INHINT;
            else if (!erasable && 17'(word) == 17'(addr) + 17'd1 && word != W_NOOP_X)
               r.mnemonic = MN_NOOP;
            else if (erasable && word == W_NOOP_E) r.mnemonic = MN_NOOP;
            else if (word == W_OVSK) r.mnemonic = MN_OVSK;
            else if (word == W_RELINT) r.mnemonic = MN_RELINT;
            else if (word == W_RESUME) r.mnemonic = MN_RESUME;
            else if (word == W_RETURN) r.mnemonic = MN_RETURN;
            else if (word == W_TCAA) r.mnemonic = MN_TCAA;
            else if (word == W_XLQ) r.mnemonic = MN_XLQ;
            else if (word == W_XXALQ) r.mnemonic = MN_XXALQ;
            else if (word == W_ZL) r.mnemonic = MN_ZL;
            else begin
               r.operand_form = FORM_ADDRESS;
               r.operand = word[11:0];
               case (group)
                  GRP_TC_READ: r.mnemonic = MN_TC;
                  GRP_CCS_DV: begin
                     if (sub == 2'd0) begin
                        r.mnemonic = MN_CCS;
                        r.operand = {2'b00, word[9:0]};
                     end else begin
                        r.mnemonic = MN_TCF;
                     end
                  end
                  GRP_DAS_MSU: begin
                     r.mnemonic = DAS_GROUP[sub];
                     r.operand = {2'b00, (r.mnemonic == MN_DAS) ? minus_one[9:0] : word[9:0]};
                  end
                  GRP_CA_DCA: r.mnemonic = MN_CA;
                  GRP_CS_DCS: r.mnemonic = MN_CS;
                  GRP_INDEX: begin
                     r.mnemonic = INDEX_GROUP[sub];
                     r.operand = {2'b00, (r.mnemonic == MN_DXCH) ? minus_one[9:0] : word[9:0]};
                  end
                  GRP_AD_SU: r.mnemonic = MN_AD;
                  default: r.mnemonic = MN_MASK;
               endcase
            end
         end else begin
            extended = 1'b0;
            if (word == W_DCOM) r.mnemonic = MN_DCOM;
            else if (word == W_RESUME) r.mnemonic = MN_RESUME;
            else if (word == W_SQUARE) r.mnemonic = MN_SQUARE;
            else if (word == W_ZL) r.mnemonic = MN_ZQ;
            else begin
               r.operand_form = FORM_ADDRESS;
               r.operand = word[11:0];
               case (group)
                  GRP_TC_READ: begin
                     r.mnemonic = MN_READ + mnemonic_type'(word[11:9]);
                     r.operand = {3'b000, word[8:0]};
                     r.operand_form = FORM_CHANNEL;
                  end
                  GRP_CCS_DV: begin
                     if (sub == 2'd0) begin
                        r.mnemonic = MN_DV;
                        r.operand = {2'b00, word[9:0]};
                     end else begin
                        r.mnemonic = MN_BZF;
                     end
                  end
                  GRP_DAS_MSU: begin
                     r.mnemonic = MSU_GROUP[sub];
                     r.operand = {2'b00, word[9:0]};
                  end
                  GRP_CA_DCA: begin
                     r.mnemonic = MN_DCA;
                     r.operand = minus_one[11:0];
                  end
                  GRP_CS_DCS: begin
                     r.mnemonic = MN_DCS;
                     r.operand = minus_one[11:0];
                  end
                  GRP_INDEX: begin
                     r.mnemonic = MN_INDEX;
                     extended = 1'b1;
                  end
                  GRP_AD_SU: begin
                     if (sub == 2'd0) begin
                        r.mnemonic = MN_SU;
                        r.operand = {2'b00, word[9:0]};
                     end else begin
                        r.mnemonic = MN_BZMF;
                     end
                  end
                  default: r.mnemonic = MN_MP;
               endcase
            end
         end
         return r;
      endfunction

      function void note_word(addr_type addr, word_type word);
         expected_q.push_back(decode(addr, word));
      endfunction

      function void compare_field(string field, int unsigned exp_val, int unsigned got_val);
         if (exp_val != got_val) begin
            $display("%0t: %s expected %0d actual %0d", $time, field, exp_val, got_val);
            failures++;
         end
      endfunction

      function void check_result(result_type got);
         result_type exp_r;
         if (expected_q.size() == 0) begin
            $display("%0t: result transfer with none expected, actual mnemonic %0d",
                     $time, got.mnemonic);
            failures++;
            return;
         end
         exp_r = expected_q.pop_front();
         compare_field("mnemonic", exp_r.mnemonic, got.mnemonic);
         compare_field("operand", exp_r.operand, got.operand);
         compare_field("operand_form", exp_r.operand_form, got.operand_form);
         compare_field("was_extracode", exp_r.was_extracode, got.was_extracode);
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   addr_type     req_address;
   word_type     req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   mnemonic_type rsp_mnemonic;
   operand_type  rsp_operand;
   form_type     rsp_operand_form;
   logic         rsp_was_extracode;

   decode_scoreboard sb = new();
   result_type       rsp_seen;
   int               stall_count = 0;
   int               sent = 0;
   bit               idling_on = 1'b1;

   agc_instruction_decoder dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_address       (req_address),
      .req_word          (req_word),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_mnemonic      (rsp_mnemonic),
      .rsp_operand       (rsp_operand),
      .rsp_operand_form  (rsp_operand_form),
      .rsp_was_extracode (rsp_was_extracode)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen = {rsp_mnemonic, rsp_operand, rsp_operand_form, rsp_was_extracode};
         sb.check_result(rsp_seen);
      end
      if (stall_count != 0) stall_count--;
      else if (idling_on && !reset && $urandom_range(0, 7) == 0)
         stall_count = $urandom_range(1, 11);
      rsp_stall <= (stall_count != 0);
   end

   function automatic addr_type rand_addr();
      if ($urandom_range(0, 1) == 0) return addr_type'($urandom_range(0, 16'o1777));
      return addr_type'($urandom());
   endfunction

   task automatic send_word(input addr_type addr, input word_type word);
      int gap;
      gap = 0;
      if (idling_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 11);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_address <= addr;
      req_word    <= word;
      do @(posedge clock); while (req_stall);
      sb.note_word(addr, word);
      sent++;
   endtask

   initial begin
      #2_000_000;
      $display("FAIL agc_instruction_decoder");
      $finish;
   end

   initial begin
      int       pick;
      addr_type a;
      reset = 1'b1;
      req_valid = 1'b0;
      req_address = '0;
      req_word = '0;
      rsp_stall = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Whole-word mnemonics, the two kinds of NOOP and the DCOM and SQUARE extracode words.
      foreach (PLAIN_SPECIALS[i]) begin
         if (PLAIN_SPECIALS[i] != W_EXTEND) send_word(16'o4000, PLAIN_SPECIALS[i]);
      end
      send_word(16'o2000, 15'o2001);
      send_word(16'd9999, W_NOOP_X);
      send_word(16'o1777, W_NOOP_E);
      send_word(16'o2000, W_NOOP_E);
      send_word(16'h0000, W_EXTEND);
      send_word(16'h0000, W_DCOM);
      send_word(16'hFFFF, W_EXTEND);
      send_word(16'hFFFF, W_EXTEND);
      send_word(16'o1000, W_EXTEND);
      send_word(16'o1000, 15'o57777);
      send_word(16'o1000, W_SQUARE);
      send_word(16'o3000, W_EXTEND);
      send_word(16'o3000, 15'o30000);
      send_word(16'hFFFF, 15'h7FFF);

      while (sent < 600) begin
         idling_on = !(sent >= 150 && sent < 230) && sent < 500;
         if (sent >= 300 && sent < 306) begin
            // Let the pipeline drain completely before continuing.
            req_valid <= 1'b0;
            do @(posedge clock); while (sb.pending() != 0);
         end
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            send_word(rand_addr(), W_EXTEND);
            case ($urandom_range(0, 9))
               0: send_word(rand_addr(), EXTRA_SPECIALS[$urandom_range(0, 4)]);
               1, 2: begin
                  send_word(rand_addr(), {GRP_INDEX, 12'($urandom())});
                  send_word(rand_addr(), word_type'($urandom()));
               end
               default: send_word(rand_addr(), word_type'($urandom()));
            endcase
         end else if (pick < 45) begin
            send_word(rand_addr(), PLAIN_SPECIALS[$urandom_range(0, 14)]);
         end else if (pick < 55) begin
            a = addr_type'($urandom_range(16'o2000, 16'h7FFE));
            send_word(a, word_type'(a + 16'd1));
         end else if (pick < 60) begin
            send_word(addr_type'($urandom_range(0, 16'o1777)), W_NOOP_E);
         end else begin
            send_word(rand_addr(), word_type'($urandom()));
         end
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (sb.pending() != 0);
      repeat (8) @(posedge clock);
      @(negedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("PASS agc_instruction_decoder");
      end else begin
         $display("FAIL agc_instruction_decoder");
      end
      $finish;
   end

endmodule
